>>> sv/usb_dfu_control_request_handler_assert.svh
// Assertion helpers for the file that checks its own logic.
`ifndef USB_DFU_CONTROL_REQUEST_HANDLER_ASSERT_SVH
`define USB_DFU_CONTROL_REQUEST_HANDLER_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define USBDFU_ASSERT_SAME(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("usbdfu assertion failed");

// The consequent must hold in the cycle after the condition.
`define USBDFU_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("usbdfu assertion failed");

`endif

>>> sv/usbdfu_pkg.sv
package usbdfu_pkg;

   localparam int ADDR_W = 23;

   typedef enum logic [1:0] {
      OP_BUS_RESET = 2'd0,
      OP_OUT_DONE  = 2'd1,
      OP_SETUP     = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SEND    = 3'd1,
      ACT_ZLP     = 3'd2,
      ACT_STALL   = 3'd3,
      ACT_PROGRAM = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      SRC_DEVICE_DESC = 3'd0,
      SRC_CONFIG_DESC = 3'd1,
      SRC_CONFIG_BYTE = 3'd2,
      SRC_ZERO_STATUS = 3'd3,
      SRC_DFU_STATUS  = 3'd4,
      SRC_DFU_STATE   = 3'd5
   } source_type;

   // Request type byte, full and with the direction bit removed.
   localparam logic [7:0] RT_STD_OUT_INTERFACE = 8'h01;
   localparam logic [6:0] RT_STD_DEVICE        = 7'h00;
   localparam logic [6:0] RT_STD_INTERFACE     = 7'h01;
   localparam logic [6:0] RT_CLASS_INTERFACE   = 7'h21;

   // Standard request codes.
   localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
   localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

   // Firmware upgrade class request codes.
   localparam logic [7:0] CLS_DOWNLOAD   = 8'd1;
   localparam logic [7:0] CLS_GET_STATUS = 8'd3;
   localparam logic [7:0] CLS_GET_STATE  = 8'd5;

   localparam logic [7:0] DESC_DEVICE = 8'd1;
   localparam logic [7:0] DESC_CONFIG = 8'd2;

   localparam logic [7:0] DFU_STATE_IDLE   = 8'd2;
   localparam logic [7:0] DFU_STATE_DNLOAD = 8'd5;

   localparam logic [15:0] LEN_CONFIG_BYTE = 16'd1;
   localparam logic [15:0] LEN_ZERO_STATUS = 16'd2;
   localparam logic [15:0] LEN_DFU_STATUS  = 16'd6;
   localparam logic [15:0] LEN_DFU_STATE   = 16'd1;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_length;
   } item_type;

   typedef struct packed {
      logic [15:0]       configuration_value;
      logic              download_mode;
      logic [ADDR_W-1:0] pending_page_address;
      logic [6:0]        device_address;
      logic              device_address_enable;
   } state_type;

   typedef struct packed {
      action_type        action;
      source_type        data_source;
      logic [15:0]       send_length;
      logic [ADDR_W-1:0] page_address;
      logic              erase_row_first;
      logic [7:0]        current_configuration;
      logic [7:0]        upgrade_state;
      logic [6:0]        bus_address;
      logic              bus_address_enabled;
   } result_type;

   // Number of trailing zero bits of a positive constant.
   function automatic int trailing_zeros(input int value);
      int count;
      int rest;
      count = 0;
      rest  = value;
      while (rest > 0 && (rest % 2) == 0) begin
         rest  = rest / 2;
         count = count + 1;
      end
      return count;
   endfunction

   // Inverse of an odd constant modulo 2**bits, by Newton iteration.
   function automatic longint odd_inverse(input longint odd, input int bits);
      longint mask;
      longint inv;
      mask = (longint'(1) <<< bits) - 1;
      inv  = odd & mask;
      for (int i = 0; i < 5; i++) begin
         inv = (inv * (2 - ((odd * inv) & mask))) & mask;
      end
      return inv;
   endfunction

endpackage

>>> sv/usbdfu_if.sv
interface usbdfu_req_if
   import usbdfu_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  request_type;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] request_length;

   modport source (output valid, opcode, request_type, request_code, request_value,
                   request_length, input ready);
   modport sink (input valid, opcode, request_type, request_code, request_value,
                 request_length, output ready);
endinterface

interface usbdfu_rsp_if
   import usbdfu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [2:0]        data_source;
   logic [15:0]       send_length;
   logic [ADDR_W-1:0] page_address;
   logic              erase_row_first;
   logic [7:0]        current_configuration;
   logic [7:0]        upgrade_state;
   logic [6:0]        bus_address;
   logic              bus_address_enabled;

   modport source (output valid, action, data_source, send_length, page_address,
                   erase_row_first, current_configuration, upgrade_state, bus_address,
                   bus_address_enabled, input ready);
   modport sink (input valid, action, data_source, send_length, page_address,
                 erase_row_first, current_configuration, upgrade_state, bus_address,
                 bus_address_enabled, output ready);
endinterface

>>> sv/usbdfu_decoder.sv
module usbdfu_decoder
   import usbdfu_pkg::*;
#(
   parameter int PAGE_BYTES = 64,
   parameter int ROW_BYTES  = 256,
   parameter int APP_BASE   = 1024
) (
   input  item_type   item,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   // Divisibility by the row size: the low power-of-two bits must be zero and
   // the rest, times the inverse of the odd factor, must not exceed the limit.
   localparam int     ROW_SHIFT = trailing_zeros(ROW_BYTES);
   localparam int     ROW_ODD   = ROW_BYTES >> ROW_SHIFT;
   localparam int     MW        = ADDR_W - ROW_SHIFT;
   localparam longint ROW_INV   = odd_inverse(longint'(ROW_ODD), MW);
   localparam longint ROW_LIMIT = ((longint'(1) <<< MW) - 1) / ROW_ODD;
   localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((longint'(1) <<< ROW_SHIFT) - 1);

   logic [ADDR_W-1:0] download_address;
   logic [MW-1:0]     row_quot;
   logic [MW-1:0]     row_prod;
   logic              row_start;
   logic [6:0]        type_bits;

   assign download_address = ADDR_W'(32'(APP_BASE) + {16'd0, item.request_value} *
                                     32'(PAGE_BYTES));

   assign row_quot  = MW'(cur.pending_page_address >> ROW_SHIFT);
   assign row_prod  = MW'(row_quot * MW'(ROW_INV));
   assign row_start = ((cur.pending_page_address & LOW_MASK) == '0) &&
                      (row_prod <= MW'(ROW_LIMIT));

   assign type_bits = item.request_type[6:0];

   always_comb begin
      nxt                 = cur;
      res                 = '0;
      res.action          = ACT_NONE;
      res.data_source     = SRC_DEVICE_DESC;
      case (item.opcode)
         OP_BUS_RESET: begin
            nxt.device_address        = '0;
            nxt.device_address_enable = 1'b1;
         end
         OP_OUT_DONE: begin
            if (cur.pending_page_address != '0) begin
               res.action               = ACT_PROGRAM;
               res.page_address         = cur.pending_page_address;
               res.erase_row_first      = row_start;
               nxt.pending_page_address = '0;
            end
         end
         OP_SETUP: begin
            if (item.request_type == RT_STD_OUT_INTERFACE) begin
               res.action = ACT_ZLP;
            end else begin
               case (type_bits)
                  RT_STD_DEVICE, RT_STD_INTERFACE: begin
                     case (item.request_code)
                        REQ_GET_DESCRIPTOR: begin
                           if (item.request_value[15:8] == DESC_DEVICE) begin
                              res.action      = ACT_SEND;
                              res.data_source = SRC_DEVICE_DESC;
                              res.send_length = item.request_length;
                           end else if (item.request_value[15:8] == DESC_CONFIG) begin
                              res.action      = ACT_SEND;
                              res.data_source = SRC_CONFIG_DESC;
                              res.send_length = item.request_length;
                           end else begin
                              res.action = ACT_STALL;
                           end
                        end
                        REQ_GET_CONFIGURATION: begin
                           res.action      = ACT_SEND;
                           res.data_source = SRC_CONFIG_BYTE;
                           res.send_length = LEN_CONFIG_BYTE;
                        end
                        REQ_GET_STATUS: begin
                           res.action      = ACT_SEND;
                           res.data_source = SRC_ZERO_STATUS;
                           res.send_length = LEN_ZERO_STATUS;
                        end
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                           res.action = ACT_STALL;
                        end
                        REQ_SET_ADDRESS: begin
                           res.action                = ACT_ZLP;
                           nxt.device_address        = item.request_value[6:0];
                           nxt.device_address_enable = 1'b1;
                        end
                        REQ_SET_CONFIGURATION: begin
                           res.action              = ACT_ZLP;
                           nxt.configuration_value = item.request_value;
                        end
                        default: begin
                        end
                     endcase
                  end
                  RT_CLASS_INTERFACE: begin
                     if (item.request_code == CLS_GET_STATUS) begin
                        res.action      = ACT_SEND;
                        res.data_source = SRC_DFU_STATUS;
                        res.send_length = LEN_DFU_STATUS;
                     end else if (item.request_code == CLS_GET_STATE) begin
                        res.action      = ACT_SEND;
                        res.data_source = SRC_DFU_STATE;
                        res.send_length = LEN_DFU_STATE;
                     end else begin
                        if (item.request_code == CLS_DOWNLOAD) begin
                           nxt.download_mode = 1'b0;
                           if (item.request_length != '0) begin
                              nxt.download_mode        = 1'b1;
                              nxt.pending_page_address = download_address;
                           end
                        end
                        // While a page waits, the status stage rides on the program.
                        if (nxt.pending_page_address == '0) begin
                           res.action = ACT_ZLP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      res.current_configuration = nxt.configuration_value[7:0];
      res.upgrade_state         = nxt.download_mode ? DFU_STATE_DNLOAD : DFU_STATE_IDLE;
      res.bus_address           = nxt.device_address;
      res.bus_address_enabled   = nxt.device_address_enable;
   end

endmodule

>>> sv/usb_dfu_control_request_handler.sv
// Channel   Dir  Handshake     Contents
// req_bus   in   valid/ready   event: opcode, request type, code, value, length
// rsp_bus   out  valid/ready   action, data source, length, page, status fields
//
// Every event yields exactly one response transaction; it passes from the input register
// through the combinational decoder into the response register. One event is taken per
// cycle while the response side is ready. Reset is synchronous and active high; it
// clears the stored device state and both valid flags. A stalled response holds the
// pipeline: the input register keeps its event, and a new request is taken only when
// that register is empty or moves on in the same cycle.
module usb_dfu_control_request_handler
   import usbdfu_pkg::*;
#(
   parameter int PAGE_BYTES = 64,
   parameter int ROW_BYTES  = 256,
   parameter int APP_BASE   = 1024
) (
   input logic         clock,
   input logic         reset,
   usbdfu_req_if.sink   req_bus,
   usbdfu_rsp_if.source rsp_bus
);

`include "usb_dfu_control_request_handler_assert.svh"

   // Input register: one event waiting for decode.
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_ff;

   // Device state kept between events.
   state_type  state_ff;
   state_type  state_in;

   // Response register.
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type result;

   logic       req_accept;
   logic       advance;

   // The decoded event moves into the response register when that register
   // is empty or is being emptied in this cycle.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_accept  = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   usbdfu_decoder #(
      .PAGE_BYTES (PAGE_BYTES),
      .ROW_BYTES  (ROW_BYTES),
      .APP_BASE   (APP_BASE)
   ) u_decoder (
      .item (in_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // State changes only when the event is committed to the response.
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.opcode         <= opcode_type'(req_bus.opcode);
         in_ff.request_type   <= req_bus.request_type;
         in_ff.request_code   <= req_bus.request_code;
         in_ff.request_value  <= req_bus.request_value;
         in_ff.request_length <= req_bus.request_length;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid                 = out_valid_ff;
   assign rsp_bus.action                = out_ff.action;
   assign rsp_bus.data_source           = out_ff.data_source;
   assign rsp_bus.send_length           = out_ff.send_length;
   assign rsp_bus.page_address          = out_ff.page_address;
   assign rsp_bus.erase_row_first       = out_ff.erase_row_first;
   assign rsp_bus.current_configuration = out_ff.current_configuration;
   assign rsp_bus.upgrade_state         = out_ff.upgrade_state;
   assign rsp_bus.bus_address           = out_ff.bus_address;
   assign rsp_bus.bus_address_enabled   = out_ff.bus_address_enabled;

   // A program order always names a real page.
   `USBDFU_ASSERT_SAME(a_program_has_page, clock, reset,
      out_valid_ff && out_ff.action == ACT_PROGRAM, out_ff.page_address != '0)
   // Only send actions carry a source and a length.
   `USBDFU_ASSERT_SAME(a_send_fields_clear, clock, reset,
      out_valid_ff && out_ff.action != ACT_SEND,
      out_ff.data_source == SRC_DEVICE_DESC && out_ff.send_length == '0)
   // The reported state follows the stored download mode, since the response
   // and the device state are loaded at the same edge.
   `USBDFU_ASSERT_SAME(a_state_matches_mode, clock, reset,
      out_valid_ff, out_ff.upgrade_state == (state_ff.download_mode ? DFU_STATE_DNLOAD :
                                             DFU_STATE_IDLE))
   // An event in the input register with an empty response side always moves on.
   `USBDFU_ASSERT_NEXT(a_event_moves_on, clock, reset,
      in_valid_ff && !out_valid_ff, out_valid_ff)
   // Download mode on means the response reports the download state.
   `USBDFU_ASSERT_SAME(a_mode_reported, clock, reset,
      advance, result.upgrade_state == (state_in.download_mode ? DFU_STATE_DNLOAD :
                                        DFU_STATE_IDLE))

endmodule
